### hw/rtl/midpoint_circle_rasterizer_macros.svh
// Assertion macros shared by the midpoint circle rasterizer checkers.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_MACROS_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MCR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/mcr_pkg.sv
// Package: constants and types of the midpoint circle rasterizer.
`timescale 1ns / 1ps

package mcr_pkg;

   localparam int SCREEN_WIDTH  = 32;
   localparam int SCREEN_HEIGHT = 32;
   localparam int BACK_BASE     = 32;
   localparam int BASE_ADDR     = BACK_BASE + SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int MAX_RESULTS   = 48;

   localparam int POS_W    = 8;   // center coordinate and loop variable width
   localparam int RADIUS_W = 6;
   localparam int COLOR_W  = 16;
   localparam int ADDR_W   = 12;
   localparam int NUM_PTS  = 8;
   localparam int ERR_W    = 10;
   localparam int COORD_W  = 10;  // signed screen coordinate, covers -63..318
   localparam int PROD_W   = 24;  // wide enough for base + row * width + column
   localparam int CNT_W    = $clog2(MAX_RESULTS);

   // Loop variables of the midpoint iteration.
   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [ERR_W-1:0] err;
   } step_state_type;

   // Eight symmetric points of one loop step.
   typedef struct packed {
      logic [NUM_PTS-1:0][ADDR_W-1:0] addr;
      logic [NUM_PTS-1:0]             mask;
   } point_set_type;

endpackage

### hw/rtl/mcr_channels.sv
// Interfaces: circle command channel and point result channel.
`timescale 1ns / 1ps

interface mcr_req_if;
   logic                           valid;
   logic                           ready;
   logic [mcr_pkg::POS_W-1:0]      center_x;
   logic [mcr_pkg::POS_W-1:0]      center_y;
   logic [mcr_pkg::RADIUS_W-1:0]   radius;
   logic [mcr_pkg::COLOR_W-1:0]    pixel_color;

   modport source (output valid, center_x, center_y, radius, pixel_color, input ready);
   modport sink (input valid, center_x, center_y, radius, pixel_color, output ready);
endinterface

interface mcr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mcr_pkg::ADDR_W-1:0]    addr_p0;
   logic [mcr_pkg::ADDR_W-1:0]    addr_p1;
   logic [mcr_pkg::ADDR_W-1:0]    addr_p2;
   logic [mcr_pkg::ADDR_W-1:0]    addr_p3;
   logic [mcr_pkg::ADDR_W-1:0]    addr_p4;
   logic [mcr_pkg::ADDR_W-1:0]    addr_p5;
   logic [mcr_pkg::ADDR_W-1:0]    addr_p6;
   logic [mcr_pkg::ADDR_W-1:0]    addr_p7;
   logic [mcr_pkg::NUM_PTS-1:0]   point_mask;
   logic [mcr_pkg::COLOR_W-1:0]   write_color;
   logic                          last_step;

   modport source (output valid, addr_p0, addr_p1, addr_p2, addr_p3, addr_p4, addr_p5,
                   addr_p6, addr_p7, point_mask, write_color, last_step, input ready);
   modport sink (input valid, addr_p0, addr_p1, addr_p2, addr_p3, addr_p4, addr_p5,
                 addr_p6, addr_p7, point_mask, write_color, last_step, output ready);
endinterface

### hw/rtl/mcr_step_unit.sv
// Step unit: one midpoint decision update of x, y and the error term.
`timescale 1ns / 1ps

module mcr_step_unit (
   input  mcr_pkg::step_state_type cur,
   output mcr_pkg::step_state_type nxt
);

   logic signed [mcr_pkg::POS_W-1:0] y_inc;
   logic signed [mcr_pkg::POS_W-1:0] x_dec;
   logic signed [mcr_pkg::ERR_W-1:0] err_mid;
   logic signed [mcr_pkg::ERR_W-1:0] y_ext;
   logic signed [mcr_pkg::ERR_W-1:0] x_ext;
   logic                             step_y;
   logic                             step_x;

   always_comb begin
      // advance y first while the error is not positive
      step_y  = (cur.err <= 0);
      y_inc   = cur.y + mcr_pkg::POS_W'(1);
      nxt.y   = step_y ? y_inc : cur.y;
      y_ext   = mcr_pkg::ERR_W'(nxt.y);
      err_mid = step_y ? (cur.err + (y_ext <<< 1) + mcr_pkg::ERR_W'(1)) : cur.err;

      // then pull x in once the error turns positive
      step_x  = (err_mid > 0);
      x_dec   = cur.x - mcr_pkg::POS_W'(1);
      nxt.x   = step_x ? x_dec : cur.x;
      x_ext   = mcr_pkg::ERR_W'(nxt.x);
      nxt.err = step_x ? (err_mid - (x_ext <<< 1) - mcr_pkg::ERR_W'(1)) : err_mid;
   end

endmodule

### hw/rtl/mcr_point_unit.sv
// Point unit: eight symmetric points, clipping and back-buffer addresses.
`timescale 1ns / 1ps

module mcr_point_unit (
   input  logic [mcr_pkg::POS_W-1:0]    center_x,
   input  logic [mcr_pkg::POS_W-1:0]    center_y,
   input  logic signed [mcr_pkg::POS_W-1:0] off_x,
   input  logic signed [mcr_pkg::POS_W-1:0] off_y,
   output mcr_pkg::point_set_type       points
);

   localparam logic signed [mcr_pkg::COORD_W-1:0] WIDTH_LIM =
      mcr_pkg::COORD_W'(mcr_pkg::SCREEN_WIDTH);
   localparam logic signed [mcr_pkg::COORD_W-1:0] HEIGHT_LIM =
      mcr_pkg::COORD_W'(mcr_pkg::SCREEN_HEIGHT);

   logic signed [mcr_pkg::COORD_W-1:0] cx, cy, dx, dy;
   logic signed [mcr_pkg::COORD_W-1:0] px [mcr_pkg::NUM_PTS];
   logic signed [mcr_pkg::COORD_W-1:0] py [mcr_pkg::NUM_PTS];
   logic [mcr_pkg::PROD_W-1:0]         full_addr [mcr_pkg::NUM_PTS];

   always_comb begin
      cx = signed'({{(mcr_pkg::COORD_W-mcr_pkg::POS_W){1'b0}}, center_x});
      cy = signed'({{(mcr_pkg::COORD_W-mcr_pkg::POS_W){1'b0}}, center_y});
      dx = mcr_pkg::COORD_W'(off_x);
      dy = mcr_pkg::COORD_W'(off_y);

      px[0] = cx + dx;  py[0] = cy + dy;
      px[1] = cx + dy;  py[1] = cy + dx;
      px[2] = cx - dy;  py[2] = cy + dx;
      px[3] = cx - dx;  py[3] = cy + dy;
      px[4] = cx - dx;  py[4] = cy - dy;
      px[5] = cx - dy;  py[5] = cy - dx;
      px[6] = cx + dy;  py[6] = cy - dx;
      px[7] = cx + dx;  py[7] = cy - dy;

      for (int i = 0; i < mcr_pkg::NUM_PTS; i++) begin
         full_addr[i] = mcr_pkg::PROD_W'(mcr_pkg::BASE_ADDR)
                      + mcr_pkg::PROD_W'(unsigned'(py[i])) * mcr_pkg::PROD_W'(mcr_pkg::SCREEN_WIDTH)
                      + mcr_pkg::PROD_W'(unsigned'(px[i]));
         // drop points off the screen, negative coordinates included
         if (px[i] < 0 || py[i] < 0 || px[i] >= WIDTH_LIM || py[i] >= HEIGHT_LIM) begin
            points.mask[i] = 1'b0;
            points.addr[i] = '0;
         end else begin
            points.mask[i] = 1'b1;
            points.addr[i] = full_addr[i][mcr_pkg::ADDR_W-1:0];
         end
      end
   end

endmodule

### hw/rtl/midpoint_circle_rasterizer.sv
// Top level: midpoint circle rasterizer with step sequencer and result register.
`timescale 1ns / 1ps

// Usage
//   req_chan takes one circle command per transaction: center_x, center_y,
//   radius and pixel_color. rsp_chan gives one transaction per loop step of
//   the midpoint circle: eight back-buffer write addresses, the on-screen
//   point_mask, write_color and last_step on the final step of the circle.
//   A circle of radius r gives about r/sqrt(2) + 1 steps, at most 46 for
//   r = 63 and never more than 48; every command gives at least one step.
// Timing
//   The command is first registered and the sequencer moves to the run
//   state; the first result is then loaded into the result register. After
//   that one result per cycle while the receiver keeps rsp_chan.ready high.
//   The shared step unit updates x, y and the error once per result, and
//   req_chan.ready is low until the last step is loaded into the result
//   register.
// Reset
//   Synchronous reset drops back to idle and empties the result register.
// Stall
//   A stalled receiver holds the result register; the sequencer waits and
//   the loop variables hold until the register frees up.
module midpoint_circle_rasterizer (
   input  logic         clock,
   input  logic         reset,
   mcr_req_if.sink      req_chan,
   mcr_rsp_if.source    rsp_chan
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic                              state_ff, state_in;
   logic [mcr_pkg::POS_W-1:0]         cx_ff, cx_in;
   logic [mcr_pkg::POS_W-1:0]         cy_ff, cy_in;
   logic [mcr_pkg::COLOR_W-1:0]       color_ff, color_in;
   mcr_pkg::step_state_type           step_ff, step_in;
   logic [mcr_pkg::CNT_W-1:0]         count_ff, count_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   mcr_pkg::point_set_type            pts_ff, pts_in;
   logic [mcr_pkg::COLOR_W-1:0]       rsp_color_ff, rsp_color_in;
   logic                              last_ff, last_in;

   mcr_pkg::step_state_type           step_next;
   mcr_pkg::point_set_type            pts_now;
   logic                              req_take;
   logic                              out_free;
   logic                              load;
   logic                              is_last;

   mcr_step_unit u_step (
      .cur (step_ff),
      .nxt (step_next)
   );

   mcr_point_unit u_points (
      .center_x (cx_ff),
      .center_y (cy_ff),
      .off_x    (step_ff.x),
      .off_y    (step_ff.y),
      .points   (pts_now)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign load           = (state_ff == ST_RUN) && out_free;
   // final step: loop condition fails next, or the step budget is used up
   assign is_last        = (count_ff == mcr_pkg::CNT_W'(mcr_pkg::MAX_RESULTS - 1))
                        || !(step_next.x >= step_next.y);

   always_comb begin
      state_in     = state_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      color_in     = color_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      pts_in       = pts_ff;
      rsp_color_in = rsp_color_ff;
      last_in      = last_ff;

      // drop the held result once the receiver takes it
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cx_in       = req_chan.center_x;
               cy_in       = req_chan.center_y;
               color_in    = req_chan.pixel_color;
               step_in.x   = mcr_pkg::POS_W'(req_chan.radius);
               step_in.y   = '0;
               step_in.err = '0;
               count_in    = '0;
               state_in    = ST_RUN;
            end
         end
         ST_RUN: begin
            if (load) begin
               // capture this step's points, then advance the loop
               rsp_valid_in = 1'b1;
               pts_in       = pts_now;
               rsp_color_in = color_ff;
               last_in      = is_last;
               step_in      = step_next;
               count_in     = count_ff + mcr_pkg::CNT_W'(1);
               if (is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      color_ff     <= color_in;
      pts_ff       <= pts_in;
      rsp_color_ff <= rsp_color_in;
      last_ff      <= last_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.addr_p0     = pts_ff.addr[0];
   assign rsp_chan.addr_p1     = pts_ff.addr[1];
   assign rsp_chan.addr_p2     = pts_ff.addr[2];
   assign rsp_chan.addr_p3     = pts_ff.addr[3];
   assign rsp_chan.addr_p4     = pts_ff.addr[4];
   assign rsp_chan.addr_p5     = pts_ff.addr[5];
   assign rsp_chan.addr_p6     = pts_ff.addr[6];
   assign rsp_chan.addr_p7     = pts_ff.addr[7];
   assign rsp_chan.point_mask  = pts_ff.mask;
   assign rsp_chan.write_color = rsp_color_ff;
   assign rsp_chan.last_step   = last_ff;

endmodule

### hw/rtl/mcr_checker.sv
// Checker: port-level assertions for the midpoint circle rasterizer.
`timescale 1ns / 1ps
`include "midpoint_circle_rasterizer_macros.svh"

module mcr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [mcr_pkg::ADDR_W-1:0]     rsp_addr_p0,
   input logic [mcr_pkg::ADDR_W-1:0]     rsp_addr_p7,
   input logic [mcr_pkg::NUM_PTS-1:0]    rsp_point_mask,
   input logic                           rsp_last_step
);

   // a new command makes the block busy
   `MCR_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready, "ready after command")
   // a circle still in flight keeps commands out
   `MCR_ASSERT_SAME(a_busy_mid_circle, clock, reset, rsp_valid && !rsp_last_step, !req_ready, "ready mid circle")
   // a stalled result stays offered
   `MCR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped")
   // clipped points carry address zero
   `MCR_ASSERT_SAME(a_clip_zero, clock, reset, rsp_valid && (!rsp_point_mask[0] || !rsp_point_mask[7]), (rsp_point_mask[0] || rsp_addr_p0 == '0) && (rsp_point_mask[7] || rsp_addr_p7 == '0), "clipped address")

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_addr_p0    (rsp_chan.addr_p0),
   .rsp_addr_p7    (rsp_chan.addr_p7),
   .rsp_point_mask (rsp_chan.point_mask),
   .rsp_last_step  (rsp_chan.last_step)
);
